### sv/swarq_pkg.sv
// Shared types, codes and constants for the sliding-window ARQ sender.
// Used by swarq_ctrl, swarq_dp and sliding_window_arq_sender; no dependencies.
package swarq_pkg;

  localparam int MaxFrames  = 256;
  localparam int WindowMax  = 16;
  localparam int SeqW       = 8;   // frame number on the ports
  localparam int CntW       = 9;   // base / next counters, reach MaxFrames
  localparam int WinW       = 5;
  localparam int TimerW     = 16;
  localparam int EndW       = 10;  // base + window
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam logic [1:0]        ModeReset    = 2'd0;
  localparam logic [WinW-1:0]   WindowReset  = 5'd4;
  localparam logic [CntW-1:0]   TotalReset   = 9'd10;
  localparam logic [TimerW-1:0] TimeoutReset = 16'd20;

  // event kinds on the input side
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_NACK = 2'd2,
    REQ_PEER = 2'd3
  } req_t;

  // operating modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_NACK  = 2'd1;
  localparam logic [1:0] MODE_PIGGY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_CMPL  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the incoming word
    logic apply;      // apply the event to next/timer/map
    logic walk_step;  // advance base by one
    logic pull_up;    // raise next to base
    logic emit_piggy;
    logic emit_send;
    logic emit_cmpl;
    logic last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ack;
    logic is_piggy;
    logic walk_more;
    logic send_avail;
    logic send_more;
    logic cmpl_pending;
    logic out_free;
    logic clr_busy;   // acked map still being cleared after reset
  } dp_status_t;

  function automatic logic [CntW-1:0] eff_total(input logic [CntW-1:0] total);
    eff_total = (total > CntW'(MaxFrames)) ? CntW'(MaxFrames) : total;
  endfunction

  function automatic logic [WinW-1:0] eff_window(input logic [WinW-1:0] win);
    if (win == '0)
      eff_window = WinW'(1);
    else if (win > WinW'(WindowMax))
      eff_window = WinW'(WindowMax);
    else
      eff_window = win;
  endfunction

endpackage

### sv/sliding_window_arq_sender.sv
// Sliding-window ARQ sender, top level: joins swarq_ctrl and swarq_dp.
// Depends on swarq_pkg, swarq_ctrl and swarq_dp.
//
// Input stream s_*: one word per event. s_tuser holds the event kind
// (tick, ack, nack, peer frame), s_tdata the frame number it carries.
// Output stream m_*: result words. m_tuser holds the result kind (data
// frame, ack, transfer complete), m_tdata the frame number (zero for
// complete), m_tlast marks the final result caused by one event.
// Configuration: cfg_we writes cfg_data to register cfg_index (mode,
// window size, total frames, timeout ticks); write only while idle.
// Flow: one event at a time. It is accepted, then applied; result words
// go out one per cycle while the receiver takes them, then back to idle.
// After an ack the base walk steps past each acked frame, and then raises
// the next frame to base if it lags, before the results go out.
// A single output register holds the pending result; when the receiver
// stalls the controller waits and nothing is dropped.
// Reset (rst, synchronous) restores register defaults, clears base, next
// frame, timer and completion flag; the acked map is then cleared entry by
// entry, with s_tready held low until it is done.
module sliding_window_arq_sender (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] seq_num
  input  logic [1:0]                        s_tuser,   // [1:0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] out_seq
  output logic [1:0]                        m_tuser,   // [1:0] out_kind
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [swarq_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [swarq_pkg::CfgDataW-1:0]    cfg_data
);

  swarq_pkg::dp_cmd_t    cmd;
  swarq_pkg::dp_status_t status;

  swarq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swarq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (s_tuser),
    .in_seq    (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_seq   (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

### sv/swarq_ctrl.sv
// Sequencer for the ARQ sender: accept, apply event, walk base, emit results.
// Depends on swarq_pkg; drives the command struct of swarq_dp.
module swarq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  swarq_pkg::dp_status_t status,
  output swarq_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_APPLY = 6'b000010,
    S_WALK  = 6'b000100,
    S_PIGGY = 6'b001000,
    S_SEND  = 6'b010000,
    S_CMPL  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE) && !status.clr_busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && !status.clr_busy) begin
          cmd.latch  = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (status.is_ack)
          state_next = S_WALK;
        else if (status.is_piggy)
          state_next = S_PIGGY;
        else
          state_next = S_SEND;
      end
      S_WALK: begin
        if (status.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.pull_up = 1'b1;
          state_next  = S_SEND;
        end
      end
      S_PIGGY: begin
        if (status.out_free) begin
          cmd.emit_piggy = 1'b1;
          cmd.last       = !(status.send_avail || status.cmpl_pending);
          state_next     = S_SEND;
        end
      end
      S_SEND: begin
        if (status.send_avail) begin
          if (status.out_free) begin
            cmd.emit_send = 1'b1;
            cmd.last      = !(status.send_more || status.cmpl_pending);
          end
        end else if (status.cmpl_pending) begin
          state_next = S_CMPL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CMPL: begin
        if (status.out_free) begin
          cmd.emit_cmpl = 1'b1;
          cmd.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/swarq_dp.sv
// Datapath of the ARQ sender: config registers, window counters, acked map,
// idle timer and the output register. Depends on swarq_pkg.
module swarq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swarq_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [swarq_pkg::CfgDataW-1:0]      cfg_data,
  input  logic [1:0]                          in_req,
  input  logic [swarq_pkg::SeqW-1:0]          in_seq,
  input  swarq_pkg::dp_cmd_t                  cmd,
  output swarq_pkg::dp_status_t               status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_kind,
  output logic [swarq_pkg::SeqW-1:0]          out_seq,
  output logic                                out_last
);

  logic [1:0]                        mode;
  logic [swarq_pkg::WinW-1:0]        win_cfg;
  logic [swarq_pkg::CntW-1:0]        total_cfg;
  logic [swarq_pkg::TimerW-1:0]      timeout_ticks;

  logic [swarq_pkg::CntW-1:0]        base;
  logic [swarq_pkg::CntW-1:0]        next_seq;
  logic                              acked_mem [swarq_pkg::MaxFrames];
  logic                              acked_rd;
  logic [swarq_pkg::SeqW-1:0]        rd_addr;
  logic                              ack_wr;
  logic                              ack_hit;
  logic                              clr_busy;
  logic [swarq_pkg::SeqW-1:0]        clr_addr;
  logic [swarq_pkg::TimerW-1:0]      idle_ticks;
  logic                              complete_sent;
  swarq_pkg::req_t                   req;
  logic [swarq_pkg::SeqW-1:0]        seq;

  logic [swarq_pkg::CntW-1:0]        total;
  logic [swarq_pkg::WinW-1:0]        win;
  logic [swarq_pkg::EndW-1:0]        win_end;
  logic [swarq_pkg::EndW-1:0]        next_inc;
  logic [swarq_pkg::CntW-1:0]        seq_ext;
  logic [swarq_pkg::TimerW-1:0]      idle_inc;

  assign total    = swarq_pkg::eff_total(total_cfg);
  assign win      = swarq_pkg::eff_window(win_cfg);
  assign win_end  = swarq_pkg::EndW'(base) + swarq_pkg::EndW'(win);
  assign next_inc = swarq_pkg::EndW'(next_seq) + swarq_pkg::EndW'(1);
  assign seq_ext  = swarq_pkg::CntW'(seq);
  assign idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;

  // read ahead one entry while stepping so acked_rd always holds the base entry
  assign rd_addr  = cmd.walk_step ? base[swarq_pkg::SeqW-1:0] + 1'b1
                                  : base[swarq_pkg::SeqW-1:0];
  assign ack_wr   = cmd.apply && (req == swarq_pkg::REQ_ACK) && (seq_ext < total);
  assign ack_hit  = ack_wr && (seq == rd_addr);

  always_comb begin
    status.is_ack       = (req == swarq_pkg::REQ_ACK);
    status.is_piggy     = (req == swarq_pkg::REQ_PEER) && (mode == swarq_pkg::MODE_PIGGY);
    status.walk_more    = (base < total) && acked_rd;
    status.send_avail   = (swarq_pkg::EndW'(next_seq) < win_end) && (next_seq < total);
    status.send_more    = (next_inc < win_end) && (next_inc < swarq_pkg::EndW'(total));
    status.cmpl_pending = (base >= total) && !complete_sent;
    status.out_free     = !out_valid || out_ready;
    status.clr_busy     = clr_busy;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= swarq_pkg::ModeReset;
      win_cfg       <= swarq_pkg::WindowReset;
      total_cfg     <= swarq_pkg::TotalReset;
      timeout_ticks <= swarq_pkg::TimeoutReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swarq_pkg::CFG_MODE:    mode          <= cfg_data[1:0];
        swarq_pkg::CFG_WINDOW:  win_cfg       <= cfg_data[swarq_pkg::WinW-1:0];
        swarq_pkg::CFG_TOTAL:   total_cfg     <= cfg_data[swarq_pkg::CntW-1:0];
        swarq_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured event word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= swarq_pkg::req_t'(in_req);
      seq <= in_seq;
    end
  end

  // clear the acked map after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1)
        clr_busy <= 1'b0;
    end
  end

  // acked map
  always_ff @(posedge clk) begin
    if (clr_busy)
      acked_mem[clr_addr] <= 1'b0;
    else if (ack_wr)
      acked_mem[seq] <= 1'b1;
  end

  // forward a same-cycle ack write to the read register
  always_ff @(posedge clk) begin
    acked_rd <= acked_mem[rd_addr] | ack_hit;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      base          <= '0;
      next_seq      <= '0;
      idle_ticks    <= '0;
      complete_sent <= 1'b0;
    end else begin
      if (cmd.apply) begin
        case (req)
          swarq_pkg::REQ_NACK: begin
            if (mode == swarq_pkg::MODE_NACK && seq_ext >= base && seq_ext < next_seq) begin
              next_seq   <= seq_ext;
              idle_ticks <= '0;
            end
          end
          swarq_pkg::REQ_TICK: begin
            if (idle_inc >= timeout_ticks && base < next_seq) begin
              next_seq   <= base;
              idle_ticks <= '0;
            end else begin
              idle_ticks <= idle_inc;
            end
          end
          default: ;
        endcase
      end
      if (cmd.walk_step)
        base <= base + 1'b1;
      if (cmd.pull_up && next_seq < base)
        next_seq <= base;
      if (cmd.emit_send) begin
        next_seq   <= next_inc[swarq_pkg::CntW-1:0];
        idle_ticks <= '0;
      end
      if (cmd.emit_cmpl)
        complete_sent <= 1'b1;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_piggy || cmd.emit_send || cmd.emit_cmpl) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_piggy) begin
      out_kind <= swarq_pkg::KIND_ACK;
      out_seq  <= seq;
      out_last <= cmd.last;
    end else if (cmd.emit_send) begin
      out_kind <= swarq_pkg::KIND_DATA;
      out_seq  <= next_seq[swarq_pkg::SeqW-1:0];
      out_last <= cmd.last;
    end else if (cmd.emit_cmpl) begin
      out_kind <= swarq_pkg::KIND_CMPL;
      out_seq  <= '0;
      out_last <= cmd.last;
    end
  end

endmodule
